>>> sv/bmpd_pkg.sv
// Shared types and constants for the BMP pixel stream decoder.
`default_nettype none

package bmpd_pkg;

  localparam int COORD_W = 14;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL      = 2'd0;
  localparam logic [1:0] KIND_BAD_SIG    = 2'd1;
  localparam logic [1:0] KIND_BAD_FORMAT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CENTER_MODE = 2'd0;
  localparam logic [1:0] REG_CENTER_X    = 2'd1;
  localparam logic [1:0] REG_CENTER_Y    = 2'd2;

  localparam logic [11:0] CENTER_X_RESET = 12'd400;
  localparam logic [11:0] CENTER_Y_RESET = 12'd240;

  // File layout.
  localparam logic [7:0] SIG_B        = 8'h42;
  localparam logic [7:0] SIG_M        = 8'h4D;
  localparam logic [5:0] OFF_SIG_B    = 6'h00;
  localparam logic [5:0] OFF_SIG_M    = 6'h01;
  localparam logic [5:0] OFF_WIDTH_LO = 6'h12;
  localparam logic [5:0] OFF_WIDTH_HI = 6'h13;
  localparam logic [5:0] OFF_WIDTH_U0 = 6'h14;
  localparam logic [5:0] OFF_WIDTH_U1 = 6'h15;
  localparam logic [5:0] OFF_HGT_LO   = 6'h16;
  localparam logic [5:0] OFF_HGT_HI   = 6'h17;
  localparam logic [5:0] OFF_HGT_U0   = 6'h18;
  localparam logic [5:0] OFF_HGT_U1   = 6'h19;
  localparam logic [5:0] OFF_DEPTH_LO = 6'h1C;
  localparam logic [5:0] OFF_DEPTH_HI = 6'h1D;
  localparam logic [5:0] OFF_HDR_LAST = 6'h35;

  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  // One classified event passed from the parser to the output stage.
  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [31:0]        color;
    logic               last;
  } event_t;

endpackage

`default_nettype wire

>>> sv/bmpd_front.sv
// Byte parser: header checks, pixel assembly and row/column tracking.
`default_nettype none

module bmpd_front import bmpd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_of_file,
  input  wire logic       q_full,
  output logic            push,
  output event_t          push_entry
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXEL  = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [5:0]       header_offset, header_offset_next;
  logic [15:0]      image_width, image_width_next;
  logic [15:0]      image_height, image_height_next;
  logic [15:0]      bit_depth, bit_depth_next;
  logic             size_overflow, size_overflow_next;
  logic [1:0]       channel_index, channel_index_next;
  logic [23:0]      partial_pixel, partial_pixel_next;
  logic [DIM_W-1:0] column_count, column_count_next;
  logic [DIM_W-1:0] row_count, row_count_next;
  logic [1:0]       pad_left, pad_left_next;

  logic             accept;
  logic [1:0]       cur_phase;
  logic [5:0]       cur_off;
  logic             cur_ovf;
  logic             bpp4;
  logic             pixel_done;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, image_end;
  logic             bad_format;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign cur_phase = start_of_file ? PH_HEADER : phase;
  assign cur_off   = start_of_file ? OFF_SIG_B : header_offset;
  assign cur_ovf   = start_of_file ? 1'b0 : size_overflow;

  assign bpp4       = (bit_depth == DEPTH_32);
  assign pixel_done = bpp4 ? (channel_index == 2'd3) : (channel_index == 2'd2);
  assign col_inc    = column_count + 1'b1;
  assign row_inc    = row_count + 1'b1;
  assign row_end    = (16'(col_inc) == image_width);
  assign image_end  = (16'(row_inc) == image_height);

  assign bad_format = cur_ovf || (image_width == 16'd0) || (image_height == 16'd0) ||
                      (image_width > 16'(MAX_DIM)) || (image_height > 16'(MAX_DIM)) ||
                      ((bit_depth != DEPTH_24) && (bit_depth != DEPTH_32));

  always_comb begin
    phase_next          = phase;
    header_offset_next  = header_offset;
    image_width_next    = image_width;
    image_height_next   = image_height;
    bit_depth_next      = bit_depth;
    size_overflow_next  = size_overflow;
    channel_index_next  = channel_index;
    partial_pixel_next  = partial_pixel;
    column_count_next   = column_count;
    row_count_next      = row_count;
    pad_left_next       = pad_left;
    push                = 1'b0;
    push_entry          = '0;
    push_entry.kind     = KIND_PIXEL;

    if (accept) begin
      phase_next         = cur_phase;
      header_offset_next = cur_off;
      size_overflow_next = cur_ovf;
      unique case (cur_phase)
        PH_HEADER: begin
          if ((cur_off == OFF_SIG_B && data_byte != SIG_B) ||
              (cur_off == OFF_SIG_M && data_byte != SIG_M)) begin
            phase_next      = PH_DONE;
            push            = 1'b1;
            push_entry.kind = KIND_BAD_SIG;
          end else begin
            case (cur_off) inside
              OFF_WIDTH_LO: image_width_next  = {8'd0, data_byte};
              OFF_WIDTH_HI: image_width_next  = {data_byte, image_width[7:0]};
              OFF_HGT_LO:   image_height_next = {8'd0, data_byte};
              OFF_HGT_HI:   image_height_next = {data_byte, image_height[7:0]};
              OFF_DEPTH_LO: bit_depth_next    = {8'd0, data_byte};
              OFF_DEPTH_HI: bit_depth_next    = {data_byte, bit_depth[7:0]};
              OFF_WIDTH_U0, OFF_WIDTH_U1, OFF_HGT_U0, OFF_HGT_U1: begin
                if (data_byte != 8'd0) size_overflow_next = 1'b1;
              end
              default: ;
            endcase
            if (cur_off == OFF_HDR_LAST) begin
              if (bad_format) begin
                phase_next      = PH_DONE;
                push            = 1'b1;
                push_entry.kind = KIND_BAD_FORMAT;
              end else begin
                phase_next         = PH_PIXEL;
                channel_index_next = 2'd0;
                column_count_next  = '0;
                row_count_next     = '0;
                pad_left_next      = 2'd0;
              end
            end else begin
              header_offset_next = cur_off + 6'd1;
            end
          end
        end
        PH_PAD: begin
          pad_left_next = (pad_left != 2'd0) ? pad_left - 2'd1 : 2'd0;
          if (pad_left_next == 2'd0) phase_next = PH_PIXEL;
        end
        PH_PIXEL: begin
          case (channel_index)
            2'd0: partial_pixel_next[7:0]   = data_byte;
            2'd1: partial_pixel_next[15:8]  = data_byte;
            2'd2: partial_pixel_next[23:16] = data_byte;
            default: ;
          endcase
          if (!pixel_done) begin
            channel_index_next = channel_index + 2'd1;
          end else begin
            channel_index_next = 2'd0;
            push               = 1'b1;
            push_entry.col     = COORD_W'(column_count);
            push_entry.row     = COORD_W'(row_count);
            push_entry.width   = COORD_W'(image_width);
            push_entry.height  = COORD_W'(image_height);
            push_entry.last    = row_end && image_end;
            // The alpha byte only exists for 32-bit pixels and is the fourth byte.
            if (bpp4) push_entry.color = {data_byte, partial_pixel};
            else      push_entry.color = {8'd0, data_byte, partial_pixel[15:0]};
            if (row_end) begin
              column_count_next = '0;
              row_count_next    = row_inc;
              if (image_end) begin
                phase_next = PH_DONE;
              end else if (!bpp4 && image_width[1:0] != 2'd0) begin
                // Three bytes a pixel leaves width mod 4 bytes of padding.
                pad_left_next = image_width[1:0];
                phase_next    = PH_PAD;
              end
            end else begin
              column_count_next = col_inc;
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_offset <= '0;
      image_width   <= '0;
      image_height  <= '0;
      bit_depth     <= '0;
      size_overflow <= 1'b0;
      channel_index <= '0;
      partial_pixel <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_left      <= '0;
    end else begin
      phase         <= phase_next;
      header_offset <= header_offset_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      bit_depth     <= bit_depth_next;
      size_overflow <= size_overflow_next;
      channel_index <= channel_index_next;
      partial_pixel <= partial_pixel_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_left      <= pad_left_next;
    end
  end

  // Pixels are only ever produced while the parser is in the pixel phase.
  a_pixel_phase: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.kind == KIND_PIXEL |-> cur_phase == PH_PIXEL)
    else $error("pixel pushed outside the pixel phase");

  // Nothing is produced once the image is finished, until a new file starts.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && !start_of_file |-> !push)
    else $error("event produced after the end of the file");

endmodule

`default_nettype wire

>>> sv/bmpd_queue.sv
// Two-entry event queue between the parser and the output stage.
`default_nettype none

module bmpd_queue import bmpd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  event_t      push_entry,
  input  wire logic   pop,
  output logic        q_full,
  output logic        q_valid,
  output event_t      head
);

  event_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

>>> sv/bmpd_back.sv
// Output stage: configuration registers, screen coordinates and result register.
`default_nettype none

module bmpd_back import bmpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [11:0]          cfg_data,
  input  wire logic                 q_valid,
  input  event_t                    head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                kind,
  output logic signed [COORD_W-1:0] pixel_x,
  output logic signed [COORD_W-1:0] pixel_y,
  output logic [31:0]               color,
  output logic                      last_pixel
);

  logic               center_mode;
  logic [11:0]        center_x;
  logic [11:0]        center_y;
  logic [COORD_W-1:0] x_calc, y_calc;
  logic               is_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_mode <= 1'b0;
      center_x    <= CENTER_X_RESET;
      center_y    <= CENTER_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_MODE: center_mode <= cfg_data[0];
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coordinates wrap at the port width, as two's complement values.
  always_comb begin
    if (center_mode) begin
      x_calc = COORD_W'(center_x) - (head.width >> 1) + head.col;
      y_calc = COORD_W'(center_y) + (head.height >> 1) - head.row;
    end else begin
      x_calc = head.col;
      y_calc = head.height - COORD_W'(1) - head.row;
    end
  end

  assign is_pixel = (head.kind == KIND_PIXEL);
  assign pop      = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind       <= head.kind;
      pixel_x    <= is_pixel ? x_calc : '0;
      pixel_y    <= is_pixel ? y_calc : '0;
      color      <= is_pixel ? head.color : 32'd0;
      last_pixel <= is_pixel && head.last;
    end
  end

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PIXEL |-> pixel_x == 0 && pixel_y == 0 && color == 0 &&
    !last_pixel)
    else $error("error result carries pixel data");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("result register loaded without becoming valid");

endmodule

`default_nettype wire

>>> sv/bmp_pixel_stream_decoder_core.sv
// Top level of the BMP 24/32-bit pixel stream decoder.
//
// The input channel (in_valid/in_ready) carries one file byte per transaction;
// start_of_file marks byte 0 of a file and restarts the parser. The output
// channel (out_valid/out_ready) carries one result per transaction: a pixel
// with screen coordinates and ARGB colour, or a bad-signature or
// unsupported-format report. Bytes that produce no result (header, padding,
// the first channels of a pixel) are simply consumed.
// A byte is taken every cycle while the receiver keeps up. The byte that
// completes a result passes through the parser into the two-entry event
// queue; the result then goes through the coordinate adders into the
// output register. When the receiver stalls, the output register holds its
// result and the queue absorbs up to two more events; in_ready falls once the
// queue is full and rises as soon as an entry is drained.
// Reset empties the queue and output register, returns the parser to byte 0
// of a file and loads centre mode 0 with the centre point at (400, 240).
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
`default_nettype none

module bmp_pixel_stream_decoder_core import bmpd_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [11:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 start_of_file,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                kind,
  output logic signed [COORD_W-1:0] pixel_x,
  output logic signed [COORD_W-1:0] pixel_y,
  output logic [31:0]               color,
  output logic                      last_pixel
);

  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  event_t push_entry;
  event_t head;

  bmpd_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  bmpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  bmpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .color     (color),
    .last_pixel(last_pixel)
  );

endmodule

`default_nettype wire
